>>> hw/rtl/sfr_pkg.sv
// shared constants and types for the stream find/replace block
package sfr_pkg;

   localparam int DATA_W      = 8;
   localparam int CFG_W       = 64;
   localparam int LEN_W       = 4;
   localparam int CSR_IDX_W   = 2;
   localparam int MAX_PAT_DEF = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_SEARCH_PATTERN  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SEARCH_LENGTH   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REPLACE_PATTERN = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REPLACE_LENGTH  = 2'd3;

   typedef struct packed {
      logic load;
      logic shift;
      logic at_fill;
      logic below_fill;
   } win_ctl_type;

   typedef struct packed {
      logic load;
      logic shift;
   } emit_ctl_type;

endpackage

>>> hw/rtl/sfr_window_cell.sv
// one window cell: holds a byte, compares it with its pattern byte, shifts to its neighbor
module sfr_window_cell
   import sfr_pkg::*;
(
   input  logic              clock,
   input  win_ctl_type       ctl,
   input  logic [DATA_W-1:0] in_byte,
   input  logic [DATA_W-1:0] pat_byte,
   input  logic [DATA_W-1:0] next_new,
   output logic [DATA_W-1:0] new_byte,
   output logic              hit
);

   logic [DATA_W-1:0] byte_ff;
   logic [DATA_W-1:0] byte_in;

   assign new_byte = ctl.at_fill ? in_byte : byte_ff;

   always_comb begin
      if (ctl.below_fill) begin
         hit = (byte_ff == pat_byte);
      end else if (ctl.at_fill) begin
         hit = (in_byte == pat_byte);
      end else begin
         hit = 1'b1;
      end
   end

   always_comb begin
      byte_in = byte_ff;
      if (ctl.load) begin
         byte_in = ctl.shift ? next_new : new_byte;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

endmodule

>>> hw/rtl/sfr_emit_cell.sv
// one output cell: loaded with a run byte, shifts toward the output on each transfer
module sfr_emit_cell
   import sfr_pkg::*;
(
   input  logic              clock,
   input  emit_ctl_type      ctl,
   input  logic              use_rep,
   input  logic [DATA_W-1:0] rep_byte,
   input  logic [DATA_W-1:0] win_byte,
   input  logic [DATA_W-1:0] next_byte,
   output logic [DATA_W-1:0] cur_byte
);

   logic [DATA_W-1:0] byte_ff;
   logic [DATA_W-1:0] byte_in;

   always_comb begin
      byte_in = byte_ff;
      if (ctl.load) begin
         byte_in = use_rep ? rep_byte : win_byte;
      end else if (ctl.shift) begin
         byte_in = next_byte;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign cur_byte = byte_ff;

endmodule

>>> hw/rtl/stream_find_replace.sv
// top level of the stream find/replace block
//
// The req channel takes one stream byte per transfer with an end-of-stream flag.
// Each transfer yields a run of zero to MAX_PATTERN bytes on the rsp channel:
// the replacement on a match, the oldest window byte once the window is full,
// and the held window bytes after the final byte. run_last marks the end of a
// run, stream_done the last byte of the stream.
// A run loads into a row of output cells and leaves one byte per cycle while
// rsp_stall is low; the first byte shows in the cycle after the req transfer. A
// new req transfer is taken as soon as the last byte of the previous run leaves,
// and one-byte runs stream at one per cycle while rsp_stall is low.
// The window is a row of MAX_PATTERN cells that compare and shift in parallel.
// While rsp_stall is high the rsp payload holds; req_stall is high while more
// than the final byte of a run waits, or while rsp_stall holds the final byte.
// Reset empties the window and the output cells, sets both lengths to one and
// both patterns to zero. The csr channel is always ready; writing the search
// length empties the window.
module stream_find_replace
   import sfr_pkg::*;
#(
   parameter int MAX_PATTERN = MAX_PAT_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [DATA_W-1:0]    req_data_byte,
   input  logic                 req_end_of_stream,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [DATA_W-1:0]    rsp_out_byte,
   output logic                 rsp_run_last,
   output logic                 rsp_stream_done,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   localparam int CNT_W = $clog2(MAX_PATTERN + 1);

   logic [CFG_W-1:0] search_ff, search_in;
   logic [CFG_W-1:0] replace_ff, replace_in;
   logic [CNT_W-1:0] slen_ff, slen_in;
   logic [CNT_W-1:0] rlen_ff, rlen_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] emit_cnt_ff, emit_cnt_in;
   logic             done_ff, done_in;

   logic             csr_fire;
   logic             in_fire;
   logic             out_fire;
   logic             full;
   logic             match;
   logic [CNT_W-1:0] run_cnt;
   logic [CNT_W-1:0] len_clamp;
   logic [LEN_W-1:0] len_raw;

   logic [MAX_PATTERN-1:0] hit;
   logic [DATA_W-1:0]      win_new [MAX_PATTERN];
   logic [DATA_W-1:0]      emit_byte [MAX_PATTERN];
   win_ctl_type            win_ctl [MAX_PATTERN];
   emit_ctl_type           emit_ctl;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid & csr_ready;

   assign rsp_valid = (emit_cnt_ff != '0);
   assign out_fire  = rsp_valid & ~rsp_stall;
   assign req_stall = (emit_cnt_ff > CNT_W'(1)) | ((emit_cnt_ff == CNT_W'(1)) & rsp_stall);
   assign in_fire   = req_valid & ~req_stall;

   assign full  = ((fill_ff + CNT_W'(1)) == slen_ff);
   assign match = full & (&hit);

   // length written as zero acts as one, above the cell count as the cell count
   assign len_raw = csr_wdata[LEN_W-1:0];
   always_comb begin
      if (len_raw == '0) begin
         len_clamp = CNT_W'(1);
      end else if (len_raw > LEN_W'(MAX_PATTERN)) begin
         len_clamp = CNT_W'(MAX_PATTERN);
      end else begin
         len_clamp = CNT_W'(len_raw);
      end
   end

   always_comb begin
      if (match) begin
         run_cnt = rlen_ff;
      end else if (req_end_of_stream) begin
         run_cnt = fill_ff + CNT_W'(1);
      end else if (full) begin
         run_cnt = CNT_W'(1);
      end else begin
         run_cnt = '0;
      end
   end

   always_comb begin
      search_in  = search_ff;
      replace_in = replace_ff;
      slen_in    = slen_ff;
      rlen_in    = rlen_ff;
      fill_in    = fill_ff;
      if (in_fire) begin
         if (match || req_end_of_stream) begin
            fill_in = '0;
         end else if (!full) begin
            fill_in = fill_ff + CNT_W'(1);
         end
      end
      if (csr_fire) begin
         case (csr_index)
            CSR_SEARCH_PATTERN: begin
               search_in = csr_wdata;
            end
            CSR_SEARCH_LENGTH: begin
               slen_in = len_clamp;
               fill_in = '0;
            end
            CSR_REPLACE_PATTERN: begin
               replace_in = csr_wdata;
            end
            CSR_REPLACE_LENGTH: begin
               rlen_in = len_clamp;
            end
            default: begin
               search_in = search_ff;
            end
         endcase
      end
   end

   always_comb begin
      emit_cnt_in = emit_cnt_ff;
      done_in     = done_ff;
      if (in_fire) begin
         emit_cnt_in = run_cnt;
         done_in     = req_end_of_stream;
      end else if (out_fire) begin
         emit_cnt_in = emit_cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         search_ff   <= '0;
         replace_ff  <= '0;
         slen_ff     <= CNT_W'(1);
         rlen_ff     <= CNT_W'(1);
         fill_ff     <= '0;
         emit_cnt_ff <= '0;
         done_ff     <= 1'b0;
      end else begin
         search_ff   <= search_in;
         replace_ff  <= replace_in;
         slen_ff     <= slen_in;
         rlen_ff     <= rlen_in;
         fill_ff     <= fill_in;
         emit_cnt_ff <= emit_cnt_in;
         done_ff     <= done_in;
      end
   end

   assign emit_ctl.load  = in_fire;
   assign emit_ctl.shift = out_fire;

   for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
      logic [DATA_W-1:0] next_new;
      logic [DATA_W-1:0] next_emit;

      if (j == MAX_PATTERN - 1) begin : g_end
         assign next_new  = '0;
         assign next_emit = '0;
      end else begin : g_mid
         assign next_new  = win_new[j+1];
         assign next_emit = emit_byte[j+1];
      end

      assign win_ctl[j].load       = in_fire;
      assign win_ctl[j].shift      = full & ~match;
      assign win_ctl[j].at_fill    = (fill_ff == CNT_W'(j));
      assign win_ctl[j].below_fill = (CNT_W'(j) < fill_ff);

      sfr_window_cell u_win (
         .clock    (clock),
         .ctl      (win_ctl[j]),
         .in_byte  (req_data_byte),
         .pat_byte (search_ff[j*DATA_W +: DATA_W]),
         .next_new (next_new),
         .new_byte (win_new[j]),
         .hit      (hit[j])
      );

      sfr_emit_cell u_emit (
         .clock     (clock),
         .ctl       (emit_ctl),
         .use_rep   (match),
         .rep_byte  (replace_ff[j*DATA_W +: DATA_W]),
         .win_byte  (win_new[j]),
         .next_byte (next_emit),
         .cur_byte  (emit_byte[j])
      );
   end

   assign rsp_out_byte    = emit_byte[0];
   assign rsp_run_last    = (emit_cnt_ff == CNT_W'(1));
   assign rsp_stream_done = (emit_cnt_ff == CNT_W'(1)) & done_ff;

   // a new run loads only while the previous one is gone or leaving
   a_load_when_drained: assert property (@(posedge clock) disable iff (reset)
      in_fire |-> (emit_cnt_ff == '0) || ((emit_cnt_ff == CNT_W'(1)) && out_fire))
      else $error("run loaded over pending output");

   a_fill_below_len: assert property (@(posedge clock) disable iff (reset)
      fill_ff < slen_ff)
      else $error("window fill reached search length");

   a_run_bounded: assert property (@(posedge clock) disable iff (reset)
      emit_cnt_ff <= CNT_W'(MAX_PATTERN))
      else $error("run longer than cell row");

   a_eos_empties: assert property (@(posedge clock) disable iff (reset)
      in_fire && req_end_of_stream |=> fill_ff == '0)
      else $error("window not empty after end of stream");

endmodule

>>> bench/tb_stream_find_replace.sv
// self-checking testbench for stream_find_replace: directed script, then randomized phases
module tb_stream_find_replace
   import sfr_pkg::*;
();

   localparam int MAX_PAT      = MAX_PAT_DEF;
   localparam int RANDOM_ITEMS = 125;
   localparam int CYCLE_LIMIT  = 400000;

   typedef struct packed {
      logic [DATA_W-1:0] out_byte;
      logic              run_last;
      logic              stream_done;
   } out_beat_type;

   typedef enum logic {ROW_REG, ROW_BYTE} row_kind_type;

   typedef struct packed {
      row_kind_type         kind;
      logic [CSR_IDX_W-1:0] idx;
      logic [CFG_W-1:0]     wdata;
      logic [DATA_W-1:0]    data;
      logic                 eos;
      logic                 typed;
      out_beat_type         want;
   } script_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [DATA_W-1:0]    req_data_byte = '0;
   logic                 req_end_of_stream = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [DATA_W-1:0]    rsp_out_byte;
   logic                 rsp_run_last;
   logic                 rsp_stream_done;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]     csr_wdata = '0;

   // predictor state
   logic [CFG_W-1:0]  srch_pat;
   logic [LEN_W-1:0]  srch_len;
   logic [CFG_W-1:0]  rplc_pat;
   logic [LEN_W-1:0]  rplc_len;
   logic [DATA_W-1:0] win [MAX_PAT];
   int unsigned       win_fill;
   out_beat_type      step_out [MAX_PAT];

   out_beat_type   pending_out [$];
   script_row_type script [$];
   logic           want_typed = 1'b0;
   out_beat_type   want_rsp = '0;
   logic           tight = 1'b0;
   int unsigned    byte_cnt = 0;
   int unsigned    mismatch_cnt = 0;
   int unsigned    cycle_cnt = 0;
   int unsigned    free_cnt = 0;
   int unsigned    stall_cnt = 0;

   stream_find_replace dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_end_of_stream (req_end_of_stream),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_run_last      (rsp_run_last),
      .rsp_stream_done   (rsp_stream_done),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic int unsigned clamp_len(input logic [LEN_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_PAT) return MAX_PAT;
      return v;
   endfunction

   function automatic void clear_window();
      for (int i = 0; i < MAX_PAT; i++) win[i] = '0;
      win_fill = 0;
   endfunction

   function automatic void load_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
      case (idx)
         CSR_SEARCH_PATTERN: srch_pat = val;
         CSR_SEARCH_LENGTH: begin
            srch_len = val[LEN_W-1:0];
            win_fill = 0;
         end
         CSR_REPLACE_PATTERN: rplc_pat = val;
         CSR_REPLACE_LENGTH: rplc_len = val[LEN_W-1:0];
         default: ;
      endcase
   endfunction

   // returns the number of output bytes one stream byte produces, written to step_out
   function automatic int rewrite_byte(input logic [DATA_W-1:0] b, input logic eos);
      int unsigned slen;
      int unsigned rlen;
      int          n;
      logic        hit;
      slen = clamp_len(srch_len);
      rlen = clamp_len(rplc_len);
      n = 0;
      if (win_fill >= slen) win_fill = 0;
      win[win_fill] = b;
      win_fill++;
      if (win_fill == slen) begin
         hit = 1'b1;
         for (int i = 0; i < slen; i++)
            if (win[i] != srch_pat[8*i +: 8]) hit = 1'b0;
         if (hit) begin
            for (int i = 0; i < rlen; i++) begin
               step_out[n] = '{rplc_pat[8*i +: 8], 1'b0, 1'b0};
               n++;
            end
            win_fill = 0;
         end else begin
            step_out[n] = '{win[0], 1'b0, 1'b0};
            n++;
            for (int i = 0; i < MAX_PAT - 1; i++) win[i] = win[i+1];
            win[MAX_PAT-1] = '0;
            win_fill--;
         end
      end
      if (eos) begin
         for (int i = 0; i < win_fill; i++) begin
            step_out[n] = '{win[i], 1'b0, 1'b0};
            n++;
         end
         clear_window();
      end
      if (n > 0) begin
         step_out[n-1].run_last = 1'b1;
         step_out[n-1].stream_done = eos;
      end
      return n;
   endfunction

   always @(posedge clock) begin : monitor
      out_beat_type want;
      int           n;
      if (reset) begin
         srch_pat = '0;
         srch_len = LEN_W'(1);
         rplc_pat = '0;
         rplc_len = LEN_W'(1);
         clear_window();
      end else if (cycle_cnt == CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d transfers outstanding", $time, pending_out.size());
         $display("tb: failure");
         $finish;
      end else begin
         cycle_cnt++;
         if (rsp_valid && !rsp_stall) begin
            if (pending_out.size() == 0) begin
               mismatch_cnt++;
               $display("%0t: unexpected transfer, expected none, got byte %h run_last %b done %b",
                        $time, rsp_out_byte, rsp_run_last, rsp_stream_done);
            end else begin
               want = pending_out.pop_front();
               if (rsp_out_byte !== want.out_byte || rsp_run_last !== want.run_last ||
                   rsp_stream_done !== want.stream_done) begin
                  mismatch_cnt++;
                  $display("%0t: mismatch, expected byte %h run_last %b done %b, got %h %b %b",
                           $time, want.out_byte, want.run_last, want.stream_done,
                           rsp_out_byte, rsp_run_last, rsp_stream_done);
               end
            end
         end
         if (csr_valid && csr_ready) load_reg(csr_index, csr_wdata);
         if (req_valid && !req_stall) begin
            n = rewrite_byte(req_data_byte, req_end_of_stream);
            if (want_typed) pending_out.push_back(want_rsp);
            else for (int i = 0; i < n; i++) pending_out.push_back(step_out[i]);
         end
      end
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 20);
   endfunction

   // receiver back-pressure
   always @(negedge clock) begin
      if (free_cnt != 0) begin
         free_cnt--;
         rsp_stall <= 1'b0;
      end else if (stall_cnt != 0) begin
         stall_cnt--;
         rsp_stall <= 1'b1;
      end else begin
         free_cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 6);
         stall_cnt = pick_gap();
         rsp_stall <= 1'b0;
      end
   end

   function automatic void put_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
      script.push_back('{ROW_REG, idx, val, 8'h00, 1'b0, 1'b0, '0});
   endfunction

   function automatic void put_byte(input logic [DATA_W-1:0] d, input logic eos,
                                    input logic typed, input out_beat_type want);
      script.push_back('{ROW_BYTE, CSR_SEARCH_PATTERN, '0, d, eos, typed, want});
   endfunction

   task automatic drive_byte(input logic [DATA_W-1:0] d, input logic eos,
                             input logic typed, input out_beat_type want);
      int unsigned gap;
      gap = tight ? 0 : pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      want_typed = typed;
      want_rsp = want;
      req_valid <= 1'b1;
      req_data_byte <= d;
      req_end_of_stream <= eos;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      byte_cnt++;
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // stop sending and let every expected transfer drain
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_out.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   function automatic logic [CFG_W-1:0] pick_len();
      logic [CFG_W-1:0] val;
      int unsigned      r;
      r = $urandom_range(0, 9);
      val = {$urandom, $urandom};
      if ($urandom_range(0, 3) != 0) val[CFG_W-1:LEN_W] = '0;
      if (r == 0) val[LEN_W-1:0] = '0;
      else if (r == 1) val[LEN_W-1:0] = LEN_W'($urandom_range(9, 15));
      else val[LEN_W-1:0] = LEN_W'($urandom_range(1, 8));
      return val;
   endfunction

   function automatic logic pick_eos();
      return $urandom_range(0, 11) == 0;
   endfunction

   task automatic random_phase();
      int unsigned       items;
      int unsigned       sent;
      int unsigned       slen;
      int unsigned       cut;
      int unsigned       r;
      logic [DATA_W-1:0] sym_a;
      logic [DATA_W-1:0] sym_b;
      logic [DATA_W-1:0] b;
      logic [CFG_W-1:0]  pat;
      settle();
      tight = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) == 0) begin
         sym_a = DATA_W'($urandom);
         sym_b = DATA_W'($urandom);
         for (int k = 0; k < MAX_PAT; k++) pat[8*k +: 8] = $urandom_range(0, 1) ? sym_a : sym_b;
      end else begin
         pat = {$urandom, $urandom};
      end
      if ($urandom_range(0, 9) < 8) write_reg(CSR_SEARCH_PATTERN, pat);
      if ($urandom_range(0, 9) < 7) write_reg(CSR_SEARCH_LENGTH, pick_len());
      if ($urandom_range(0, 9) < 7) write_reg(CSR_REPLACE_PATTERN, {$urandom, $urandom});
      if ($urandom_range(0, 9) < 7) write_reg(CSR_REPLACE_LENGTH, pick_len());
      items = $urandom_range(8, 30);
      sent = 0;
      while (sent < items) begin
         slen = clamp_len(srch_len);
         r = $urandom_range(0, 9);
         if ($urandom_range(0, 24) == 0) settle();
         if (r < 5) begin
            // whole pattern, sometimes with one byte corrupted
            cut = ($urandom_range(0, 3) == 0) ? $urandom_range(0, slen - 1) : slen;
            for (int k = 0; k < slen; k++) begin
               b = srch_pat[8*k +: 8];
               if (k == cut) b = b ^ (8'h01 << $urandom_range(0, 7));
               drive_byte(b, pick_eos(), 1'b0, '0);
               sent++;
            end
         end else if (r < 8) begin
            cut = $urandom_range(0, slen - 1);
            drive_byte(srch_pat[8*cut +: 8], pick_eos(), 1'b0, '0);
            sent++;
         end else begin
            b = DATA_W'($urandom);
            drive_byte(b, pick_eos(), 1'b0, '0);
            sent++;
         end
      end
   endtask

   initial begin : stimulus
      script_row_type row;
      int unsigned    directed_cnt;

      // defaults: one-byte search for zero, replaced by zero
      put_byte(8'h00, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b0});
      put_byte(8'hFF, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b1});
      put_byte(8'h80, 1'b0, 1'b1, '{8'h80, 1'b1, 1'b0});
      put_reg(CSR_SEARCH_PATTERN, 64'h0000_0000_0063_6261);
      put_reg(CSR_SEARCH_LENGTH, 64'd3);
      put_reg(CSR_REPLACE_PATTERN, 64'hF0E1_D2C3_B4A5_9687);
      put_reg(CSR_REPLACE_LENGTH, 64'd8);
      put_byte(8'h61, 1'b0, 1'b0, '0);
      put_byte(8'h62, 1'b0, 1'b0, '0);
      put_byte(8'h63, 1'b0, 1'b0, '0);
      // window kept across a pattern change
      put_byte(8'h61, 1'b0, 1'b0, '0);
      put_byte(8'h62, 1'b0, 1'b0, '0);
      put_reg(CSR_SEARCH_PATTERN, 64'h0000_0000_0064_6261);
      put_byte(8'h64, 1'b0, 1'b0, '0);
      // window dropped by a length write, then flushed short
      put_byte(8'h61, 1'b0, 1'b0, '0);
      put_byte(8'h62, 1'b0, 1'b0, '0);
      put_reg(CSR_SEARCH_LENGTH, 64'd3);
      put_byte(8'h64, 1'b1, 1'b0, '0);
      // out-of-range lengths
      put_reg(CSR_SEARCH_LENGTH, 64'd0);
      put_reg(CSR_SEARCH_PATTERN, 64'hFFFF_FFFF_FFFF_FFFF);
      put_reg(CSR_REPLACE_LENGTH, 64'd9);
      put_byte(8'hFF, 1'b0, 1'b0, '0);
      put_byte(8'h01, 1'b1, 1'b1, '{8'h01, 1'b1, 1'b1});
      put_reg(CSR_SEARCH_LENGTH, 64'd15);
      put_reg(CSR_SEARCH_PATTERN, 64'h0);
      put_reg(CSR_REPLACE_LENGTH, 64'd0);
      for (int i = 0; i < 8; i++) put_byte(8'h00, 1'b0, 1'b0, '0);
      put_byte(8'h00, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b1});

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (script[i]) begin
         row = script[i];
         if (row.kind == ROW_REG) begin
            settle();
            write_reg(row.idx, row.wdata);
         end else begin
            drive_byte(row.data, row.eos, row.typed, row.want);
         end
      end
      directed_cnt = byte_cnt;

      while (byte_cnt < directed_cnt + RANDOM_ITEMS) random_phase();

      req_valid <= 1'b0;
      while (pending_out.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (mismatch_cnt == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
